[rtl/core/crpo_pkg.sv]
package crpo_pkg;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  localparam logic CFG_BLOCK_COUNT = 1'b0;
  localparam logic CFG_ENTRY_BLOCK = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_SCAN,
    S_CLEAR,
    S_WALK_TOP,
    S_WALK_RD,
    S_WALK_CHK,
    S_WALK_PUSH2,
    S_NUM_RD,
    S_NUM_OUT,
    S_OUT_WAIT
  } state_t;

endpackage

[rtl/core/cfg_reverse_postorder_unit.sv]
// Reverse-postorder numbering unit. Edges are loaded one per transfer
// (command add) into per-block successor lists; each load answers with one
// status result after a serial scan of the list through the successor
// memory's single read port. Index errors answer on the next cycle. A clear
// answers on the next cycle and then holds the input off while the count
// memory is cleared one entry per cycle; the same pass runs after reset. A
// run walks the graph depth first from entry_block, skipping successors that
// are out of range or already visited and popping a block once its list is
// done, then emits one result per block in block-id order, each waiting while
// the output is stalled. Unreachable blocks report reachable 0 and number 0.
// One item is processed at a time.
module cfg_reverse_postorder_unit import crpo_pkg::*; #(
  parameter int MAX_BLOCKS     = 64,
  parameter int MAX_SUCCESSORS = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_command,
  input  logic [5:0] in_source_block,
  input  logic [5:0] in_target_block,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_block_index,
  output logic [5:0] out_order_number,
  output logic       out_reachable,
  output logic [1:0] out_status,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data
);

  localparam int BW = $clog2(MAX_BLOCKS);
  localparam int SW = $clog2(MAX_SUCCESSORS);
  localparam int CW = $clog2(MAX_SUCCESSORS + 1);
  localparam int NW = BW + 1;
  localparam int TD = MAX_BLOCKS << SW;
  localparam int TW = BW + SW;

  // Configuration registers.
  logic [6:0] block_count_r;
  logic [5:0] entry_block_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r <= 7'd1;
      entry_block_r <= 6'd0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_BLOCK_COUNT) block_count_r <= cfg_data;
      else entry_block_r <= cfg_data[5:0];
    end
  end

  // Effective block count, clamped to 1..MAX_BLOCKS.
  logic [NW-1:0] live_n;
  always_comb begin
    if (block_count_r == 7'd0) live_n = NW'(1);
    else if (32'(block_count_r) > MAX_BLOCKS) live_n = NW'(MAX_BLOCKS);
    else live_n = NW'(block_count_r);
  end

  // Memories: successor table, successor counts, stack, postorder numbers.
  logic [5:0]    tbl_mem [TD];
  logic [CW-1:0] cnt_mem [MAX_BLOCKS];
  logic [5:0]    stk_blk_mem [MAX_BLOCKS];
  logic [CW-1:0] stk_nxt_mem [MAX_BLOCKS];
  logic [5:0]    ord_mem [MAX_BLOCKS];
  // Visited marks are flops, cleared at the start of each run.
  logic [MAX_BLOCKS-1:0] vis_r;

  logic [TW-1:0] tbl_raddr, tbl_waddr;
  logic          tbl_we;
  logic [5:0]    tbl_wdata, tbl_rdata;
  logic [BW-1:0] cnt_raddr, cnt_waddr;
  logic          cnt_we;
  logic [CW-1:0] cnt_wdata, cnt_rdata;
  logic [BW-1:0] stk_raddr, stk_waddr;
  logic          stk_we;
  logic [5:0]    stk_wblk, stk_rblk;
  logic [CW-1:0] stk_wnxt, stk_rnxt;
  logic [BW-1:0] ord_raddr, ord_waddr;
  logic          ord_we;
  logic [5:0]    ord_wdata, ord_rdata;

  always_ff @(posedge clk) begin
    if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
    tbl_rdata <= tbl_mem[tbl_raddr];
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rdata <= cnt_mem[cnt_raddr];
    if (stk_we) begin
      stk_blk_mem[stk_waddr] <= stk_wblk;
      stk_nxt_mem[stk_waddr] <= stk_wnxt;
    end
    stk_rblk <= stk_blk_mem[stk_raddr];
    stk_rnxt <= stk_nxt_mem[stk_raddr];
    if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
    ord_rdata <= ord_mem[ord_raddr];
  end

  // Control registers.
  state_t        state_r, state_nxt;
  logic [5:0]    src_r, src_nxt, dst_r, dst_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [NW-1:0] top_r, top_nxt;
  logic [NW-1:0] post_r, post_nxt;
  logic [NW-1:0] blk_r, blk_nxt;
  logic          found_r, found_nxt;
  logic          ov_r, ov_nxt;
  logic [5:0]    o_id_r, o_id_nxt, o_num_r, o_num_nxt;
  logic          o_reach_r, o_reach_nxt, o_last_r, o_last_nxt;
  logic [1:0]    o_st_r, o_st_nxt;
  state_t        ret_r, ret_nxt;
  logic          vis_clr, vis_set;
  logic [BW-1:0] vis_addr;

  assign in_stall = (state_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_block_index = o_id_r;
  assign out_order_number = o_num_r;
  assign out_reachable = o_reach_r;
  assign out_status = o_st_r;
  assign out_last = o_last_r;

  logic          in_xfer, out_xfer;
  logic [CW-1:0] cur_cnt;
  assign in_xfer = in_valid && !in_stall;
  assign out_xfer = ov_r && !out_stall;
  assign cur_cnt = (32'(cnt_rdata) > MAX_SUCCESSORS) ? CW'(MAX_SUCCESSORS) : cnt_rdata;

  always_comb begin
    state_nxt = state_r;
    src_nxt = src_r; dst_nxt = dst_r; idx_nxt = idx_r;
    top_nxt = top_r; post_nxt = post_r; blk_nxt = blk_r;
    found_nxt = found_r; ret_nxt = ret_r;
    ov_nxt = ov_r && out_stall;
    o_id_nxt = o_id_r; o_num_nxt = o_num_r; o_reach_nxt = o_reach_r;
    o_st_nxt = o_st_r; o_last_nxt = o_last_r;
    tbl_raddr = {src_r[BW-1:0], idx_r[SW-1:0]};
    tbl_we = 1'b0; tbl_waddr = {src_r[BW-1:0], cur_cnt[SW-1:0]}; tbl_wdata = dst_r;
    stk_raddr = BW'(top_r - NW'(1));
    stk_we = 1'b0; stk_waddr = '0; stk_wblk = '0; stk_wnxt = '0;
    ord_raddr = blk_r[BW-1:0];
    ord_we = 1'b0; ord_waddr = src_r[BW-1:0]; ord_wdata = 6'(post_r);
    cnt_raddr = src_r[BW-1:0];
    cnt_we = 1'b0; cnt_waddr = src_r[BW-1:0];
    cnt_wdata = cur_cnt + CW'(1);
    vis_clr = 1'b0; vis_set = 1'b0; vis_addr = dst_r[BW-1:0];
    unique case (state_r)
      S_IDLE: begin
        cnt_raddr = in_source_block[BW-1:0];
        if (in_xfer) begin
          src_nxt = in_source_block; dst_nxt = in_target_block;
          idx_nxt = '0; found_nxt = 1'b0;
          unique case (cmd_t'(in_command))
            CMD_ADD: begin
              if (NW'(in_source_block) >= live_n || NW'(in_target_block) >= live_n) begin
                o_id_nxt = in_source_block; o_num_nxt = '0; o_reach_nxt = 1'b0;
                o_st_nxt = ST_RANGE; o_last_nxt = 1'b1; ov_nxt = 1'b1;
              end else state_nxt = S_ADD_RD;
            end
            CMD_RUN: begin
              if (NW'(entry_block_r) >= live_n) begin
                o_id_nxt = entry_block_r; o_num_nxt = '0; o_reach_nxt = 1'b0;
                o_st_nxt = ST_RANGE; o_last_nxt = 1'b1; ov_nxt = 1'b1;
              end else begin
                // Push the entry block.
                vis_clr = 1'b1;
                vis_set = 1'b1; vis_addr = entry_block_r[BW-1:0];
                stk_we = 1'b1; stk_waddr = '0; stk_wblk = entry_block_r; stk_wnxt = '0;
                top_nxt = NW'(1); post_nxt = '0;
                state_nxt = S_WALK_TOP;
              end
            end
            CMD_CLEAR: begin
              blk_nxt = '0;
              state_nxt = S_CLEAR;
              o_id_nxt = '0; o_num_nxt = '0; o_reach_nxt = 1'b0;
              o_st_nxt = ST_OK; o_last_nxt = 1'b1; ov_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_CLEAR: begin
        // Clear one count entry per cycle.
        cnt_we = 1'b1; cnt_waddr = blk_r[BW-1:0]; cnt_wdata = '0;
        blk_nxt = blk_r + NW'(1);
        if (blk_r == NW'(MAX_BLOCKS - 1)) state_nxt = S_IDLE;
      end
      S_ADD_RD: begin
        // Scan position idx_r: issue read, compare next cycle.
        if (idx_r >= cur_cnt) begin
          if (found_r) begin
            o_st_nxt = ST_OK;
          end else if (32'(cur_cnt) >= MAX_SUCCESSORS) begin
            o_st_nxt = ST_FULL;
          end else begin
            tbl_we = 1'b1; cnt_we = 1'b1; o_st_nxt = ST_OK;
          end
          o_id_nxt = src_r; o_num_nxt = '0; o_reach_nxt = 1'b0; o_last_nxt = 1'b1;
          ret_nxt = S_IDLE; state_nxt = S_OUT_WAIT;
        end else state_nxt = S_ADD_SCAN;
      end
      S_ADD_SCAN: begin
        if (tbl_rdata == dst_r) found_nxt = 1'b1;
        idx_nxt = idx_r + CW'(1);
        state_nxt = S_ADD_RD;
      end
      S_WALK_TOP: begin
        if (top_r == '0) begin
          blk_nxt = '0; state_nxt = S_NUM_RD;
        end else state_nxt = S_WALK_RD;
      end
      S_WALK_RD: begin
        // Stack top data is valid; fetch its next successor and its count.
        src_nxt = stk_rblk; idx_nxt = stk_rnxt;
        tbl_raddr = {stk_rblk[BW-1:0], stk_rnxt[SW-1:0]};
        cnt_raddr = stk_rblk[BW-1:0];
        state_nxt = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (idx_r >= cur_cnt) begin
          // Pop: record postorder.
          ord_we = 1'b1;
          post_nxt = post_r + NW'(1);
          top_nxt = top_r - NW'(1);
          stk_raddr = BW'(top_r - NW'(2));
          state_nxt = S_WALK_TOP;
        end else begin
          idx_nxt = idx_r + CW'(1);
          if (NW'(tbl_rdata) < live_n && !vis_r[tbl_rdata[BW-1:0]] &&
              32'(top_r) < MAX_BLOCKS) begin
            vis_set = 1'b1; vis_addr = tbl_rdata[BW-1:0];
            stk_we = 1'b1; stk_waddr = BW'(top_r - NW'(1));
            stk_wblk = src_r; stk_wnxt = idx_r + CW'(1);
            top_nxt = top_r + NW'(1);
            state_nxt = S_WALK_PUSH2;
            dst_nxt = tbl_rdata;
          end else begin
            tbl_raddr = {src_r[BW-1:0], SW'(idx_r + CW'(1))};
          end
        end
      end
      S_WALK_PUSH2: begin
        stk_we = 1'b1; stk_waddr = BW'(top_r - NW'(1));
        stk_wblk = dst_r; stk_wnxt = '0;
        stk_raddr = BW'(top_r - NW'(1));
        state_nxt = S_WALK_TOP;
      end
      S_NUM_RD: begin
        state_nxt = S_NUM_OUT;
      end
      S_NUM_OUT: begin
        // Load the next result only once the output register is free.
        if (!ov_r || out_xfer) begin
          o_id_nxt = 6'(blk_r); o_st_nxt = ST_OK;
          o_reach_nxt = vis_r[blk_r[BW-1:0]];
          o_num_nxt = vis_r[blk_r[BW-1:0]] ?
                      6'(post_r - NW'(1) - NW'(ord_rdata)) : '0;
          o_last_nxt = (blk_r + NW'(1) == live_n);
          blk_nxt = blk_r + NW'(1);
          ret_nxt = (blk_r + NW'(1) == live_n) ? S_IDLE : S_NUM_RD;
          state_nxt = S_OUT_WAIT;
        end
      end
      S_OUT_WAIT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          state_nxt = ret_r;
          ord_raddr = blk_r[BW-1:0];
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ov_r <= 1'b0;
      vis_r <= '0;
      blk_r <= '0;
      top_r <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      blk_r <= blk_nxt;
      top_r <= top_nxt;
      if (vis_clr) vis_r <= {{(MAX_BLOCKS-1){1'b0}}, 1'b1} << vis_addr;
      else if (vis_set) vis_r[vis_addr] <= 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    src_r <= src_nxt; dst_r <= dst_nxt; idx_r <= idx_nxt;
    post_r <= post_nxt;
    found_r <= found_nxt; ret_r <= ret_nxt;
    o_id_r <= o_id_nxt; o_num_r <= o_num_nxt; o_reach_r <= o_reach_nxt;
    o_st_r <= o_st_nxt; o_last_r <= o_last_nxt;
  end

  // Checks.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_run_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reachable) |-> (out_status == ST_OK))
    else $error("reachable result with error status");
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(top_r) <= MAX_BLOCKS || state_r == S_IDLE) else $error("stack overflow");

endmodule

[sim/cfg_reverse_postorder_unit_test.sv]
module cfg_reverse_postorder_unit_test import crpo_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = 64;
  localparam int NSUCC = 4;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    logic [5:0] block_index;
    logic [5:0] order_number;
    logic       reachable;
    status_t    status;
    logic       last;
  } numbering_t;

  // One directed step: either an item or a register write.
  typedef struct {
    bit         is_cfg;
    int         op;
    int         src;
    int         dst;
    bit         typed;
    numbering_t want;
  } step_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_command = CMD_NONE;
  logic [5:0] in_source_block = '0;
  logic [5:0] in_target_block = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [5:0] out_block_index;
  logic [5:0] out_order_number;
  logic       out_reachable;
  logic [1:0] out_status;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_index = CFG_BLOCK_COUNT;
  logic [6:0] cfg_data = '0;

  cfg_reverse_postorder_unit dut (.*);

  always #5 clk = ~clk;

  // Mirror of the block's graph and registers.
  logic [5:0] succ_list [NBLK][NSUCC];
  int         succ_len [NBLK];
  int         nodes_reg;
  int         entry_reg;
  numbering_t pending_results[$];
  int         error_count = 0;
  int         cycle_count = 0;
  bit         calm = 1'b0;

  function automatic int live_nodes();
    if (nodes_reg < 1) return 1;
    if (nodes_reg > NBLK) return NBLK;
    return nodes_reg;
  endfunction

  function automatic numbering_t make_result(int id, int num, bit reach, status_t st, bit lst);
    numbering_t r;
    r.block_index = id[5:0];
    r.order_number = num[5:0];
    r.reachable = reach;
    r.status = st;
    r.last = lst;
    return r;
  endfunction

  // Depth-first walk from the entry; one numbering per block or a range error.
  function automatic void number_blocks(ref numbering_t res[$]);
    int n, top, post, b, ci, cnt, s;
    bit mark [NBLK];
    int stk_blk [NBLK];
    int stk_next [NBLK];
    int post_pos [NBLK];
    bit pushed;
    n = live_nodes();
    if (entry_reg >= n) begin
      res.push_back(make_result(entry_reg, 0, 1'b0, ST_RANGE, 1'b1));
      return;
    end
    foreach (mark[i]) mark[i] = 1'b0;
    stk_blk[0] = entry_reg;
    stk_next[0] = 0;
    top = 1;
    post = 0;
    mark[entry_reg] = 1'b1;
    while (top > 0) begin
      b = stk_blk[top-1];
      ci = stk_next[top-1];
      cnt = succ_len[b];
      pushed = 1'b0;
      while (ci < cnt && !pushed) begin
        s = succ_list[b][ci];
        ci++;
        if (s < n && !mark[s] && top < NBLK) begin
          mark[s] = 1'b1;
          stk_next[top-1] = ci;
          stk_blk[top] = s;
          stk_next[top] = 0;
          top++;
          pushed = 1'b1;
        end
      end
      if (!pushed) begin
        post_pos[b] = post;
        post++;
        top--;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (mark[i]) res.push_back(make_result(i, post - 1 - post_pos[i], 1'b1, ST_OK, i + 1 == n));
      else res.push_back(make_result(i, 0, 1'b0, ST_OK, i + 1 == n));
    end
  endfunction

  // Predict the results of one accepted item and update the mirror.
  function automatic void predict_item(int op, int src, int dst, ref numbering_t res[$]);
    int n;
    bit dup;
    n = live_nodes();
    case (op)
      CMD_ADD: begin
        if (src >= n || dst >= n) begin
          res.push_back(make_result(src, 0, 1'b0, ST_RANGE, 1'b1));
        end else begin
          dup = 1'b0;
          for (int i = 0; i < succ_len[src]; i++) if (succ_list[src][i] == dst) dup = 1'b1;
          if (dup) begin
            res.push_back(make_result(src, 0, 1'b0, ST_OK, 1'b1));
          end else if (succ_len[src] >= NSUCC) begin
            res.push_back(make_result(src, 0, 1'b0, ST_FULL, 1'b1));
          end else begin
            succ_list[src][succ_len[src]] = dst[5:0];
            succ_len[src]++;
            res.push_back(make_result(src, 0, 1'b0, ST_OK, 1'b1));
          end
        end
      end
      CMD_RUN: number_blocks(res);
      CMD_CLEAR: begin
        foreach (succ_len[i]) succ_len[i] = 0;
        res.push_back(make_result(0, 0, 1'b0, ST_OK, 1'b1));
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    error_count++;
  endtask

  function automatic int gap_length();
    if (calm) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 30);
  endfunction

  // Alternate between stretches with and without idling; stop at the cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 150 == 0) calm <= ($urandom_range(0, 2) == 0);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cfg_reverse_postorder_unit_test failed");
      $finish;
    end
  end

  // Offer one item and wait for its transfer; the mirror is updated on acceptance.
  task automatic send_item(int op, int src, int dst, bit typed, numbering_t want);
    numbering_t res[$];
    int gap;
    gap = gap_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= op[1:0];
    in_source_block <= src[5:0];
    in_target_block <= dst[5:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(op, src, dst, res);
    if (typed) pending_results.push_back(want);
    else foreach (res[i]) pending_results.push_back(res[i]);
  endtask

  // Register writes happen only once the block has drained and gone idle.
  task automatic write_register(int idx, int value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || in_stall) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx[0];
    cfg_data <= value[6:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_BLOCK_COUNT) nodes_reg = value & 127;
    else entry_reg = value & 63;
  endtask

  // Result side: check every transfer, stall at random, and hold off once for long.
  initial begin
    numbering_t got, exp_r;
    int taken, hold;
    bit held;
    taken = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got = {out_block_index, out_order_number, out_reachable, status_t'(out_status),
               out_last};
        taken++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result for block %0d", out_block_index));
        end else begin
          exp_r = pending_results.pop_front();
          if (got.block_index != exp_r.block_index)
            report_mismatch($sformatf("block_index %0d, want %0d", got.block_index,
                                      exp_r.block_index));
          if (got.order_number != exp_r.order_number)
            report_mismatch($sformatf("block %0d order %0d, want %0d", exp_r.block_index,
                                      got.order_number, exp_r.order_number));
          if (got.reachable != exp_r.reachable)
            report_mismatch($sformatf("block %0d reachable %0b, want %0b", exp_r.block_index,
                                      got.reachable, exp_r.reachable));
          if (got.status != exp_r.status)
            report_mismatch($sformatf("block %0d status %0d, want %0d", exp_r.block_index,
                                      got.status, exp_r.status));
          if (got.last != exp_r.last)
            report_mismatch($sformatf("block %0d last %0b, want %0b", exp_r.block_index,
                                      got.last, exp_r.last));
        end
      end
      if (!held && taken >= 300) begin
        held = 1'b1;
        out_stall <= 1'b1;
        for (hold = 0; hold < 600; hold++) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        hold = gap_length();
        out_stall <= (hold > 0);
        if (hold > 1) begin
          repeat (hold - 1) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Directed steps, then random phases over several register settings.
  initial begin
    step_t steps[$];
    step_t st;
    numbering_t none;
    int settings[8][2] = '{'{8, 0}, '{64, 5}, '{3, 2}, '{1, 0}, '{127, 63}, '{0, 0},
                           '{16, 15}, '{64, 63}};
    int n, r, src, dst;
    none = '0;
    foreach (succ_len[i]) succ_len[i] = 0;
    nodes_reg = 1;
    entry_reg = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset the graph has one block and the walk starts at it.
    steps.push_back('{0, CMD_RUN, 0, 0, 1, make_result(0, 0, 1, ST_OK, 1)});
    steps.push_back('{0, CMD_ADD, 0, 0, 1, make_result(0, 0, 0, ST_OK, 1)});
    steps.push_back('{0, CMD_ADD, 63, 0, 1, make_result(63, 0, 0, ST_RANGE, 1)});
    steps.push_back('{0, CMD_ADD, 0, 63, 1, make_result(0, 0, 0, ST_RANGE, 1)});
    steps.push_back('{0, CMD_NONE, 63, 63, 0, none});
    steps.push_back('{0, CMD_CLEAR, 0, 0, 1, make_result(0, 0, 0, ST_OK, 1)});
    steps.push_back('{1, CFG_BLOCK_COUNT, 64, 0, 0, none});
    steps.push_back('{1, CFG_ENTRY_BLOCK, 63, 0, 0, none});
    // Fill one list, repeat an edge, then overflow the list.
    steps.push_back('{0, CMD_ADD, 63, 62, 1, make_result(63, 0, 0, ST_OK, 1)});
    steps.push_back('{0, CMD_ADD, 63, 62, 1, make_result(63, 0, 0, ST_OK, 1)});
    steps.push_back('{0, CMD_ADD, 63, 0, 0, none});
    steps.push_back('{0, CMD_ADD, 63, 1, 0, none});
    steps.push_back('{0, CMD_ADD, 63, 2, 0, none});
    steps.push_back('{0, CMD_ADD, 63, 5, 1, make_result(63, 0, 0, ST_FULL, 1)});
    steps.push_back('{0, CMD_ADD, 62, 63, 0, none});
    steps.push_back('{0, CMD_RUN, 0, 0, 0, none});
    // Shrinking the graph leaves stale successors and an entry out of range.
    steps.push_back('{1, CFG_BLOCK_COUNT, 2, 0, 0, none});
    steps.push_back('{0, CMD_RUN, 0, 0, 1, make_result(63, 0, 0, ST_RANGE, 1)});
    steps.push_back('{1, CFG_ENTRY_BLOCK, 0, 0, 0, none});
    steps.push_back('{0, CMD_ADD, 0, 1, 0, none});
    steps.push_back('{0, CMD_RUN, 0, 0, 0, none});
    steps.push_back('{1, CFG_BLOCK_COUNT, 0, 0, 0, none});
    steps.push_back('{0, CMD_RUN, 0, 0, 0, none});
    steps.push_back('{1, CFG_BLOCK_COUNT, 127, 0, 0, none});
    steps.push_back('{0, CMD_RUN, 0, 0, 0, none});
    foreach (steps[i]) begin
      st = steps[i];
      if (st.is_cfg) write_register(st.op, st.src);
      else send_item(st.op, st.src, st.dst, st.typed, st.want);
    end

    // Random phases: mostly valid edges and runs, some noise.
    foreach (settings[p]) begin
      write_register(CFG_BLOCK_COUNT, settings[p][0]);
      write_register(CFG_ENTRY_BLOCK, settings[p][1]);
      n = live_nodes();
      for (int k = 0; k < 24; k++) begin
        r = $urandom_range(0, 99);
        src = $urandom_range(0, n - 1);
        dst = $urandom_range(0, n - 1);
        if (r < 70) send_item(CMD_ADD, src, dst, 0, none);
        else if (r < 82) send_item(CMD_RUN, src, dst, 0, none);
        else if (r < 87) send_item(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63), 0, none);
        else if (r < 95) send_item(CMD_ADD, $urandom_range(0, 63), $urandom_range(0, 63), 0, none);
        else send_item(CMD_NONE, $urandom_range(0, 63), $urandom_range(0, 63), 0, none);
      end
      send_item(CMD_RUN, 0, 0, 0, none);
    end
    in_valid <= 1'b0;

    // Drain, then let the block settle before the verdict.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) $display("cfg_reverse_postorder_unit_test passed");
    else $display("cfg_reverse_postorder_unit_test failed");
    $finish;
  end

endmodule
